// ===== src/obd_pkg.sv =====
// Shared types and constants for the orthonormal basis pipeline.
// No dependencies; imported by every module in src.
`default_nettype none

package obd_pkg;

  localparam int DIR_W = 24;
  localparam int OUT_W = 18;
  localparam int LIM_W = 16;
  localparam int VW = 50;
  localparam int MW = 49;
  localparam int NRM_W = 30;
  localparam int SUM_W = 62;
  localparam int ROOT_W = 31;
  localparam int NUM_W = 47;
  localparam int QUO_W = 17;
  localparam int ADDR_W = 4;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = QUO_W;
  localparam int NORM_LAT = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int PIPE_LAT = 8 + 2 * NORM_LAT;

  typedef logic signed [VW-1:0] wide_t;
  typedef logic [MW-1:0] mag_t;
  typedef logic signed [OUT_W-1:0] unit_t;
  typedef logic signed [DIR_W-1:0] dir_t;

  localparam unit_t ONE_Q16 = unit_t'({1'b1, 16'h0000});
  localparam wide_t ONE_Q32 = wide_t'({1'b1, 32'h0000_0000});

  typedef enum logic [2:0] {
    CASE_ZERO,
    CASE_PAR_X,
    CASE_Y_AXIS,
    CASE_Y_RED,
    CASE_Z_RED
  } case_t;

  typedef enum logic [1:0] {
    REG_ZERO_LIMIT,
    REG_AXIS_LIMIT,
    REG_INDEP_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [LIM_W-1:0] zero_limit;
    logic [LIM_W-1:0] axis_limit;
    logic [LIM_W-1:0] independence_limit;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic [2:0] neg;
    logic [2:0][NRM_W-1:0] m;
  } nside_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic [2:0] neg;
  } dside_t;

  typedef struct packed {
    logic zero;
    logic par;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
    logic signed [DIR_W-1:0] dz;
  } p1_t;

  typedef struct packed {
    case_t code;
    logic signed [OUT_W-1:0] b1x;
    logic signed [OUT_W-1:0] b1y;
    logic signed [OUT_W-1:0] b1z;
  } p2_t;

endpackage

`default_nettype wire

// ===== src/obd_cfg.sv =====
// APB register file holding the three limits.
// Depends on obd_pkg.
`default_nettype none

module obd_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [obd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output obd_pkg::cfg_t                  cfg
);
  import obd_pkg::*;

  logic    wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_limit <= 16'd43;
      cfg.axis_limit <= 16'd1;
      cfg.independence_limit <= 16'd4295;
    end else if (wr) begin
      unique case (idx)
        REG_ZERO_LIMIT:  cfg.zero_limit <= pwdata[LIM_W-1:0];
        REG_AXIS_LIMIT:  cfg.axis_limit <= pwdata[LIM_W-1:0];
        REG_INDEP_LIMIT: cfg.independence_limit <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ZERO_LIMIT:  prdata = 32'(cfg.zero_limit);
      REG_AXIS_LIMIT:  prdata = 32'(cfg.axis_limit);
      REG_INDEP_LIMIT: prdata = 32'(cfg.independence_limit);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/obd_isqrt.sv =====
// Pipelined integer square root, one result bit per stage (one radicand bit pair per stage).
// Depends on obd_pkg.
`default_nettype none

module obd_isqrt (
  input  wire logic                       clk,
  input  wire logic [obd_pkg::SUM_W-1:0]  rad,
  output logic      [obd_pkg::ROOT_W-1:0] root
);
  import obd_pkg::*;

  logic [63:0] v_q [SQRT_STEPS];
  logic [63:0] r_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BV = 64'(1) << (62 - 2 * k);
    logic [63:0] vi, ri, t;
    if (k == 0) begin : g_first
      assign vi = 64'(rad);
      assign ri = '0;
    end else begin : g_next
      assign vi = v_q[k-1];
      assign ri = r_q[k-1];
    end
    assign t = ri + BV;
    always_ff @(posedge clk) begin
      if (vi >= t) begin
        v_q[k] <= vi - t;
        r_q[k] <= (ri >> 1) + BV;
      end else begin
        v_q[k] <= vi;
        r_q[k] <= ri >> 1;
      end
    end
  end

  assign root = r_q[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== src/obd_div.sv =====
// Pipelined restoring divider lane, one quotient bit per stage.
// Depends on obd_pkg; quotient must fit in QUO_W bits.
`default_nettype none

module obd_div (
  input  wire logic                       clk,
  input  wire logic [obd_pkg::NUM_W-1:0]  num,
  input  wire logic [obd_pkg::ROOT_W-1:0] den,
  output logic      [obd_pkg::QUO_W-1:0]  quo
);
  import obd_pkg::*;

  logic [31:0]       r_q [DIV_STEPS];
  logic [QUO_W-1:0]  q_q [DIV_STEPS];
  logic [QUO_W-1:0]  n_q [DIV_STEPS];
  logic [ROOT_W-1:0] d_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [31:0]       ri, t;
    logic [QUO_W-1:0]  qi, ni;
    logic [ROOT_W-1:0] di;
    if (k == 0) begin : g_first
      assign ri = 32'(num[NUM_W-1:QUO_W]);
      assign qi = '0;
      assign ni = num[QUO_W-1:0];
      assign di = den;
    end else begin : g_next
      assign ri = r_q[k-1];
      assign qi = q_q[k-1];
      assign ni = n_q[k-1];
      assign di = d_q[k-1];
    end
    assign t = {ri[30:0], ni[QUO_W-1-k]};
    always_ff @(posedge clk) begin
      d_q[k] <= di;
      n_q[k] <= ni;
      if (t >= 32'(di)) begin
        r_q[k] <= t - 32'(di);
        q_q[k] <= {qi[QUO_W-2:0], 1'b1};
      end else begin
        r_q[k] <= t;
        q_q[k] <= {qi[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign quo = q_q[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== src/obd_norm.sv =====
// Vector normaliser to Q1.16: range shift, sum of squares, root, divide.
// Depends on obd_pkg, obd_isqrt, obd_div.
`default_nettype none

module obd_norm (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire obd_pkg::wide_t vin [3],
  output logic                out_valid,
  output obd_pkg::unit_t      vout [3]
);
  import obd_pkg::*;

  logic             s0_v, s1_v, s2_v, s3_v, s4_v, sn_v, so_v;
  mag_t             s0_m [3], s1_m [3];
  mag_t             s0_mx;
  logic [2:0]       s0_neg, s1_neg, s2_neg, s3_neg, s4_neg;
  logic             s1_zero, s2_zero, s3_zero, s4_zero;
  logic [5:0]       s1_pos, pos_next;
  logic [NRM_W-1:0] s2_m [3], s3_m [3], s4_m [3];
  logic [59:0]      s3_sq [3];
  logic [SUM_W-1:0] s4_sum;
  mag_t             m_next [3];
  mag_t             mx_next;
  nside_t           sq_pipe [SQRT_STEPS];
  nside_t           sq_tail;
  logic [ROOT_W-1:0] root;
  logic [NUM_W-1:0] sn_num [3];
  logic [ROOT_W-1:0] sn_den;
  logic             sn_zero;
  logic [2:0]       sn_neg;
  dside_t           dv_pipe [DIV_STEPS];
  dside_t           sn_side;
  logic [QUO_W-1:0] quo [3];

  always_comb begin
    mx_next = '0;
    for (int i = 0; i < 3; i++) begin
      m_next[i] = mag_t'(vin[i][VW-1] ? -vin[i] : vin[i]);
      if (m_next[i] > mx_next) mx_next = m_next[i];
    end
  end

  always_comb begin
    pos_next = '0;
    for (int i = 0; i < MW; i++) begin
      if (s0_mx[i]) pos_next = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      sn_v <= 1'b0;
      so_v <= 1'b0;
    end else begin
      s0_v <= in_valid;
      s1_v <= s0_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      sn_v <= sq_tail.valid;
      so_v <= sn_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_mx <= mx_next;
    s1_pos <= pos_next;
    s1_zero <= (s0_mx == '0);
    s2_zero <= s1_zero;
    s3_zero <= s2_zero;
    s4_zero <= s3_zero;
    s4_sum <= SUM_W'(s3_sq[0]) + SUM_W'(s3_sq[1]) + SUM_W'(s3_sq[2]);
    for (int i = 0; i < 3; i++) begin
      s0_m[i] <= m_next[i];
      s0_neg[i] <= vin[i][VW-1];
      s1_m[i] <= s0_m[i];
      s1_neg[i] <= s0_neg[i];
      s2_neg[i] <= s1_neg[i];
      s3_neg[i] <= s2_neg[i];
      s4_neg[i] <= s3_neg[i];
      if (s1_pos >= 6'd29) s2_m[i] <= NRM_W'(s1_m[i] >> (s1_pos - 6'd29));
      else s2_m[i] <= NRM_W'(s1_m[i] << (6'd29 - s1_pos));
      s3_m[i] <= s2_m[i];
      s3_sq[i] <= 60'(s2_m[i]) * 60'(s2_m[i]);
      s4_m[i] <= s3_m[i];
    end
  end

  obd_isqrt u_isqrt (
    .clk  (clk),
    .rad  (s4_sum),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_STEPS; k++) sq_pipe[k].valid <= 1'b0;
    end else begin
      sq_pipe[0].valid <= s4_v;
      for (int k = 1; k < SQRT_STEPS; k++) sq_pipe[k].valid <= sq_pipe[k-1].valid;
    end
    sq_pipe[0].zero <= s4_zero;
    sq_pipe[0].neg <= s4_neg;
    for (int i = 0; i < 3; i++) sq_pipe[0].m[i] <= s4_m[i];
    for (int k = 1; k < SQRT_STEPS; k++) begin
      sq_pipe[k].zero <= sq_pipe[k-1].zero;
      sq_pipe[k].neg <= sq_pipe[k-1].neg;
      sq_pipe[k].m <= sq_pipe[k-1].m;
    end
  end

  assign sq_tail = sq_pipe[SQRT_STEPS-1];

  // round half up: (m * 2^16 + n/2) / n
  always_ff @(posedge clk) begin
    sn_den <= root;
    sn_zero <= sq_tail.zero;
    sn_neg <= sq_tail.neg;
    for (int i = 0; i < 3; i++) begin
      sn_num[i] <= NUM_W'({sq_tail.m[i], 16'h0000}) + NUM_W'(root >> 1);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    obd_div u_div (
      .clk (clk),
      .num (sn_num[i]),
      .den (sn_den),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) dv_pipe[k].valid <= 1'b0;
    end else begin
      dv_pipe[0].valid <= sn_v;
      for (int k = 1; k < DIV_STEPS; k++) dv_pipe[k].valid <= dv_pipe[k-1].valid;
    end
    dv_pipe[0].zero <= sn_zero;
    dv_pipe[0].neg <= sn_neg;
    for (int k = 1; k < DIV_STEPS; k++) begin
      dv_pipe[k].zero <= dv_pipe[k-1].zero;
      dv_pipe[k].neg <= dv_pipe[k-1].neg;
    end
  end

  // dv_pipe is loaded from the sn_ registers, like the divider lanes, so its last stage lines up with quo
  assign sn_side = dv_pipe[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (sn_side.zero) vout[i] <= '0;
      else if (sn_side.neg[i]) vout[i] <= -unit_t'(quo[i]);
      else vout[i] <= unit_t'(quo[i]);
    end
  end

  assign out_valid = so_v;

endmodule

`default_nettype wire

// ===== src/orthonormal_basis_of_direction.sv =====
// Top level: two unit vectors perpendicular to a Q8.16 direction.
// Depends on obd_pkg, obd_cfg, obd_norm.
`default_nettype none

// One direction is taken every clock; busy never rises. Each result appears
// on the result ports with done high for one cycle. The path from a direction
// to its result runs through two normalisers in series, each 56 stages long
// (a 32-stage square root and a 17-stage divider per component). Limits must
// be written through the APB port only while no direction is in flight; the
// block itself does not enforce this.
module orthonormal_basis_of_direction (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [23:0]         dir_x,
  input  wire logic signed [23:0]         dir_y,
  input  wire logic signed [23:0]         dir_z,
  output logic                            done,
  output logic signed [17:0]              first_x,
  output logic signed [17:0]              first_y,
  output logic signed [17:0]              first_z,
  output logic signed [17:0]              second_x,
  output logic signed [17:0]              second_y,
  output logic signed [17:0]              second_z,
  output logic [2:0]                      case_code,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [obd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import obd_pkg::*;

  cfg_t  cfg;
  logic  a_v, b_v, c_v, e_v, f_v, g_v, h_v;
  dir_t  a_d [3];
  dir_t  b_d [3];
  logic signed [47:0] b_sq [3];
  logic signed [47:0] b_xy, b_xz;
  logic [MW-1:0] p_next, len_next;
  wide_t c_vec [3];
  wide_t c_dir [3];
  p1_t   c_side;
  p1_t   p1_pipe [NORM_LAT];
  p1_t   p1_tail;
  logic  b1_ov, nor_ov;
  unit_t b1_o [3];
  unit_t nor_o [3];
  unit_t e_b1 [3];
  unit_t e_nor [3];
  p1_t   e_side;
  logic signed [41:0] e_c1, e_c2;
  logic  e_ax;
  logic [DIR_W-1:0] dy_mag;
  logic [OUT_W-1:0] b1y_mag;
  logic signed [42:0] c_diff;
  logic [42:0] c_mag;
  case_t code_next;
  unit_t f_b1 [3];
  unit_t f_nor [3];
  case_t f_code;
  unit_t nt, bt;
  logic signed [35:0] g_pn [3];
  logic signed [35:0] g_pb [3];
  unit_t g_b1 [3];
  case_t g_code;
  wide_t h_vec [3];
  p2_t   h_side;
  p2_t   p2_pipe [NORM_LAT];
  p2_t   p2_tail;
  logic  b2_ov;
  unit_t b2_o [3];
  logic  o_v;

  assign busy = 1'b0;

  obd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      o_v <= 1'b0;
    end else begin
      a_v <= start && !busy;
      b_v <= a_v;
      c_v <= b_v;
      e_v <= b1_ov;
      f_v <= e_v;
      g_v <= f_v;
      h_v <= g_v;
      o_v <= b2_ov;
    end
  end

  // front: squares and cross products, then limit tests
  assign p_next = MW'(b_sq[1]) + MW'(b_sq[2]);
  assign len_next = MW'(b_sq[0]) + p_next;

  always_ff @(posedge clk) begin
    a_d[0] <= dir_x;
    a_d[1] <= dir_y;
    a_d[2] <= dir_z;
    for (int i = 0; i < 3; i++) begin
      b_d[i] <= a_d[i];
      b_sq[i] <= a_d[i] * a_d[i];
      c_dir[i] <= wide_t'(b_d[i]);
    end
    b_xy <= a_d[0] * a_d[1];
    b_xz <= a_d[0] * a_d[2];
    c_vec[0] <= wide_t'({1'b0, p_next});
    c_vec[1] <= -wide_t'(b_xy);
    c_vec[2] <= -wide_t'(b_xz);
    c_side.zero <= len_next <= MW'(cfg.zero_limit);
    c_side.par <= p_next < MW'(cfg.zero_limit);
    c_side.dx <= b_d[0];
    c_side.dy <= b_d[1];
    c_side.dz <= b_d[2];
  end

  obd_norm u_norm_b1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_v),
    .vin       (c_vec),
    .out_valid (b1_ov),
    .vout      (b1_o)
  );

  obd_norm u_norm_dir (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_v),
    .vin       (c_dir),
    .out_valid (nor_ov),
    .vout      (nor_o)
  );

  always_ff @(posedge clk) begin
    p1_pipe[0] <= c_side;
    for (int k = 1; k < NORM_LAT; k++) p1_pipe[k] <= p1_pipe[k-1];
  end

  assign p1_tail = p1_pipe[NORM_LAT-1];

  // middle: case decision
  assign dy_mag = DIR_W'(p1_tail.dy[DIR_W-1] ? -p1_tail.dy : p1_tail.dy);
  assign b1y_mag = OUT_W'(b1_o[1][OUT_W-1] ? -b1_o[1] : b1_o[1]);
  assign c_diff = 43'(e_c1) - 43'(e_c2);
  assign c_mag = 43'(c_diff[42] ? -c_diff : c_diff);

  always_comb begin
    if (e_side.zero) code_next = CASE_ZERO;
    else if (e_side.par) code_next = CASE_PAR_X;
    else if (e_ax) code_next = CASE_Y_AXIS;
    else if (c_mag > 43'(cfg.independence_limit)) code_next = CASE_Y_RED;
    else code_next = CASE_Z_RED;
  end

  assign nt = (f_code == CASE_Y_RED) ? f_nor[1] : f_nor[2];
  assign bt = (f_code == CASE_Y_RED) ? f_b1[1] : f_b1[2];

  always_ff @(posedge clk) begin
    e_side <= p1_tail;
    e_c1 <= b1_o[0] * p1_tail.dz;
    e_c2 <= b1_o[2] * p1_tail.dx;
    e_ax <= (dy_mag < DIR_W'(cfg.axis_limit)) && (b1y_mag < OUT_W'(cfg.axis_limit));
    f_code <= code_next;
    g_code <= f_code;
    for (int i = 0; i < 3; i++) begin
      e_b1[i] <= b1_o[i];
      e_nor[i] <= nor_o[i];
      f_b1[i] <= e_b1[i];
      f_nor[i] <= e_nor[i];
      g_b1[i] <= f_b1[i];
      g_pn[i] <= nt * f_nor[i];
      g_pb[i] <= bt * f_b1[i];
      if ((g_code == CASE_Y_RED && i == 1) || (g_code != CASE_Y_RED && i == 2)) begin
        h_vec[i] <= ONE_Q32 - wide_t'(g_pn[i]) - wide_t'(g_pb[i]);
      end else begin
        h_vec[i] <= -wide_t'(g_pn[i]) - wide_t'(g_pb[i]);
      end
    end
    h_side.code <= g_code;
    h_side.b1x <= g_b1[0];
    h_side.b1y <= g_b1[1];
    h_side.b1z <= g_b1[2];
  end

  obd_norm u_norm_b2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h_v),
    .vin       (h_vec),
    .out_valid (b2_ov),
    .vout      (b2_o)
  );

  always_ff @(posedge clk) begin
    p2_pipe[0] <= h_side;
    for (int k = 1; k < NORM_LAT; k++) p2_pipe[k] <= p2_pipe[k-1];
  end

  assign p2_tail = p2_pipe[NORM_LAT-1];

  // back: select the result for the case
  always_ff @(posedge clk) begin
    case_code <= p2_tail.code;
    case (p2_tail.code)
      CASE_ZERO: begin
        first_x <= '0;
        first_y <= '0;
        first_z <= '0;
        second_x <= '0;
        second_y <= '0;
        second_z <= '0;
      end
      CASE_PAR_X: begin
        first_x <= '0;
        first_y <= ONE_Q16;
        first_z <= '0;
        second_x <= '0;
        second_y <= '0;
        second_z <= ONE_Q16;
      end
      CASE_Y_AXIS: begin
        first_x <= p2_tail.b1x;
        first_y <= p2_tail.b1y;
        first_z <= p2_tail.b1z;
        second_x <= '0;
        second_y <= ONE_Q16;
        second_z <= '0;
      end
      default: begin
        first_x <= p2_tail.b1x;
        first_y <= p2_tail.b1y;
        first_z <= p2_tail.b1z;
        second_x <= b2_o[0];
        second_y <= b2_o[1];
        second_z <= b2_o[2];
      end
    endcase
  end

  assign done = o_v;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("result strobe missing after fixed latency");

  a_norm_align: assert property (@(posedge clk) disable iff (rst)
    b1_ov == nor_ov)
    else $error("normaliser outputs out of step");

  a_zero_case: assert property (@(posedge clk) disable iff (rst)
    (done && case_code == CASE_ZERO) |->
      (first_x == 0 && first_y == 0 && first_z == 0 &&
       second_x == 0 && second_y == 0 && second_z == 0))
    else $error("zero direction gave non-zero basis");

  a_axis_case: assert property (@(posedge clk) disable iff (rst)
    (done && (case_code == CASE_PAR_X || case_code == CASE_Y_AXIS)) |->
      (second_x == 0 && (second_y == ONE_Q16 || second_z == ONE_Q16)))
    else $error("fixed second vector wrong");

endmodule

`default_nettype wire
